// ===== design/lmsl_pkg.sv =====
// ============================================================================
// lmsl_pkg
// Shared types and constants for the monotone subsequence length engine.
// ============================================================================
package lmsl_pkg;

    // Width of the value field as it appears on the input channel.
    localparam int VALUE_W = 32;
    // Width of the reported length field.
    localparam int LEN_W   = 9;

    // Order codes held in the configuration register.
    typedef enum logic
    {
        ORDER_INCREASING = 1'b0,
        ORDER_DECREASING = 1'b1
    } order_t;

    // Payload of one input transaction.
    typedef struct packed
    {
        logic signed [VALUE_W-1:0] value;
        logic                      last_in_sequence;
    } in_item_t;

    // Payload of one result transaction.
    typedef struct packed
    {
        logic [LEN_W-1:0] length_so_far;
        logic             overflowed;
        logic             sequence_done;
    } out_item_t;

    // Control part of the token that walks down the cell chain.
    typedef struct packed
    {
        logic   valid;   // a token occupies this slot
        order_t order;   // order captured when the element entered
        logic   last;    // element closes the sequence
        logic   placed;  // element already stored in an earlier cell
    } tok_ctrl_t;

endpackage

// ===== design/lmsl_if.sv =====
// ============================================================================
// lmsl_if
// Valid/ready channel carrying one payload of a chosen type.
// ============================================================================
interface lmsl_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source
    (
        output valid,
        output data,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  data,
        output ready
    );
endinterface

// ===== design/lmsl_cell.sv =====
// ============================================================================
// lmsl_cell
// One tail slot of the chain: compares the passing element and may take it.
// ============================================================================
module lmsl_cell #(
    parameter int VALUE_BITS = 32,
    parameter int CNT_W      = 9
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          prev_occ,
    input  lmsl_pkg::tok_ctrl_t           tok_in,
    input  logic signed [VALUE_BITS-1:0]  val_in,
    input  logic        [CNT_W-1:0]       cnt_in,
    output logic                          occ,
    output lmsl_pkg::tok_ctrl_t           tok_out,
    output logic signed [VALUE_BITS-1:0]  val_out,
    output logic        [CNT_W-1:0]       cnt_out
);

    logic                         occ_reg;
    logic                         occ_next;
    logic signed [VALUE_BITS-1:0] tail_reg;
    logic signed [VALUE_BITS-1:0] tail_next;
    lmsl_pkg::tok_ctrl_t          tok_reg;
    lmsl_pkg::tok_ctrl_t          tok_next;
    logic signed [VALUE_BITS-1:0] val_reg;
    logic        [CNT_W-1:0]      cnt_reg;
    logic        [CNT_W-1:0]      cnt_next;
    logic                         tail_ahead;
    logic                         hit;

    // The stored tail is strictly before the element in the active order.
    always_comb
    begin
        unique case (tok_in.order)
            lmsl_pkg::ORDER_DECREASING: tail_ahead = tail_reg > val_in;
            lmsl_pkg::ORDER_INCREASING: tail_ahead = tail_reg < val_in;
            default:                    tail_ahead = tail_reg < val_in;
        endcase
    end

    // An empty slot is always the first one past the occupied prefix.
    assign hit = tok_in.valid && !tok_in.placed && (!occ_reg || !tail_ahead);

    always_comb
    begin
        occ_next  = occ_reg;
        tail_next = tail_reg;
        if (tok_in.valid)
        begin
            occ_next = tok_in.last ? 1'b0 : (occ_reg | hit);
            if (hit)
            begin
                tail_next = val_in;
            end
        end
        tok_next        = tok_in;
        tok_next.placed = tok_in.placed | hit;
        cnt_next        = cnt_in + CNT_W'(occ_reg | hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            tok_reg <= '0;
        end
        else if (adv)
        begin
            occ_reg <= occ_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tail_reg <= tail_next;
            val_reg  <= val_in;
            cnt_reg  <= cnt_next;
        end
    end

    assign occ     = occ_reg;
    assign tok_out = tok_reg;
    assign val_out = val_reg;
    assign cnt_out = cnt_reg;

    // Occupied slots form a prefix of the chain, except right behind a
    // closing element that has emptied the previous slot and now sits here.
    a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg |-> (prev_occ || (tok_in.valid && tok_in.last)))
        else $error("cell occupied while its predecessor is empty");

    // A closing element leaves the slot empty behind it.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && tok_in.valid && tok_in.last) |=> !occ_reg)
        else $error("slot not cleared after end of sequence");

    // An unplaced element reaching an empty slot is stored there.
    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && tok_in.valid && !tok_in.last && !tok_in.placed && !occ_reg)
        |=> (occ_reg && tok_out.placed))
        else $error("append into empty slot was lost");

endmodule

// ===== design/lmsl_out.sv =====
// ============================================================================
// lmsl_out
// Result register and sticky overflow flag at the end of the cell chain.
// ============================================================================
module lmsl_out #(
    parameter int CNT_W = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lmsl_pkg::tok_ctrl_t  tok,
    input  logic [CNT_W-1:0]     cnt,
    input  logic                 res_ready,
    output logic                 adv,
    output logic                 res_valid,
    output lmsl_pkg::out_item_t  res_data
);

    localparam int EXT_W = CNT_W + lmsl_pkg::LEN_W;

    logic                valid_reg;
    logic                ovf_seen_reg;
    logic                ovf_seen_next;
    lmsl_pkg::out_item_t data_reg;
    lmsl_pkg::out_item_t data_next;
    logic [EXT_W-1:0]    cnt_ext;
    logic                ovf_now;

    // The whole chain moves whenever the result slot is free or being taken.
    assign adv = !valid_reg || res_ready;

    // An element that passed every cell unplaced was dropped.
    assign ovf_now = tok.valid && !tok.placed;
    assign cnt_ext = EXT_W'(cnt);

    always_comb
    begin
        ovf_seen_next           = ovf_seen_reg;
        if (tok.valid)
        begin
            ovf_seen_next = tok.last ? 1'b0 : (ovf_seen_reg | ovf_now);
        end
        data_next.length_so_far = cnt_ext[lmsl_pkg::LEN_W-1:0];
        data_next.overflowed    = ovf_seen_reg | ovf_now;
        data_next.sequence_done = tok.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            ovf_seen_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg    <= tok.valid;
            ovf_seen_reg <= ovf_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

    // The overflow flag does not survive the end of a sequence.
    a_ovf_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && tok.valid && tok.last) |=> !ovf_seen_reg)
        else $error("overflow flag kept past end of sequence");

    // Once an overflow is seen, every later result in the sequence shows it.
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && tok.valid && ovf_seen_reg) |=> (res_valid && res_data.overflowed))
        else $error("sticky overflow not reported");

endmodule

// ===== design/longest_monotone_subsequence_length_top.sv =====
// ============================================================================
// longest_monotone_subsequence_length_top
// Running length of the longest strictly monotone subsequence of a stream.
// ============================================================================
//
//  Channel   Role     Payload                                       Transaction
//  item      sink     value[31:0] signed, last_in_sequence          one element
//  result    source   length_so_far[8:0], overflowed, sequence_done one result
//  cfg       sink     order_descending (1 bit)                      reg write
//
//  One element is accepted per cycle while the result channel does not stall;
//  its result passes through the register of every cell in the chain and then
//  through the result register, from which it can be taken.
//  Reset clears the occupancy of every cell, the overflow flag and the order.
//  A stall on the result channel freezes the entire chain and the input side.
//  No clearing pass is needed after reset; the block is ready at once.
//
// Each cell holds one subsequence tail. An element enters cell 0 and moves one
// cell per cycle while the chain advances. The first cell whose tail is not
// strictly before the element (or the first empty cell) takes the element. Since
// every earlier element is further down the chain, each cell is already up to
// date when a new element reaches it, so elements can follow each other back to
// back. On its way the element counts the occupied cells, which gives the tail
// count after it. An element marked last empties every cell it passes, so the
// next sequence starts with a clean chain right behind it.
// ============================================================================
module longest_monotone_subsequence_length_top #(
    parameter int MAX_TAILS  = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic  clk,
    input  logic  rst_n,
    lmsl_if.sink   item,
    lmsl_if.source result,
    lmsl_if.sink   cfg
);

    localparam int CNT_W = $clog2(MAX_TAILS + 1);

    logic                         adv;
    logic                         order_reg;
    logic signed [VALUE_BITS-1:0] val_entry;

    lmsl_pkg::tok_ctrl_t          ctrl  [0:MAX_TAILS];
    logic signed [VALUE_BITS-1:0] vals  [0:MAX_TAILS];
    logic        [CNT_W-1:0]      cnts  [0:MAX_TAILS];
    logic                         occs  [0:MAX_TAILS];

    // The configuration register may be written at any cycle.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= lmsl_pkg::ORDER_INCREASING;
        end
        else if (cfg.valid)
        begin
            order_reg <= cfg.data;
        end
    end

    // Take the low VALUE_BITS bits of the element, sign-extended if wider.
    generate
        if (VALUE_BITS <= lmsl_pkg::VALUE_W)
        begin : g_narrow
            assign val_entry = item.data.value[VALUE_BITS-1:0];
        end
        else
        begin : g_wide
            assign val_entry = VALUE_BITS'(item.data.value);
        end
    endgenerate

    // The input is accepted whenever the chain advances.
    assign item.ready = adv;

    // Token entering the first cell; a bubble when no element is offered.
    always_comb
    begin
        ctrl[0].valid  = item.valid;
        ctrl[0].order  = lmsl_pkg::order_t'(order_reg);
        ctrl[0].last   = item.data.last_in_sequence;
        ctrl[0].placed = 1'b0;
    end
    assign vals[0] = val_entry;
    assign cnts[0] = '0;
    assign occs[0] = 1'b1;

    generate
        for (genvar i = 0; i < MAX_TAILS; i++)
        begin : g_cell
            lmsl_cell #(
                .VALUE_BITS (VALUE_BITS),
                .CNT_W      (CNT_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .prev_occ (occs[i]),
                .tok_in   (ctrl[i]),
                .val_in   (vals[i]),
                .cnt_in   (cnts[i]),
                .occ      (occs[i+1]),
                .tok_out  (ctrl[i+1]),
                .val_out  (vals[i+1]),
                .cnt_out  (cnts[i+1])
            );
        end
    endgenerate

    // The element value is not needed past the last cell; it only feeds the
    // tail compare, so the last cell's value and occupancy go unread.
    lmsl_out #(
        .CNT_W (CNT_W)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (ctrl[MAX_TAILS]),
        .cnt       (cnts[MAX_TAILS]),
        .res_ready (result.ready),
        .adv       (adv),
        .res_valid (result.valid),
        .res_data  (result.data)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the monotone subsequence length engine. Elements
// are pushed through the item channel while a behavioral copy of the tail
// array predicts every result. Each result is checked field by field against
// the oldest prediction, under random idling and back-pressure on both sides.
// ============================================================================
module testbench;

    // The block is built at its default sizes; the bench keeps its own copy.
    localparam int MAX_TAILS   = 256;
    // Long enough for the whole chain to fill behind a stalled result port.
    localparam int HOLD_CYCLES = 3 * MAX_TAILS;

    typedef logic signed [lmsl_pkg::VALUE_W-1:0] value_t;

    localparam value_t VALUE_MIN = {1'b1, {(lmsl_pkg::VALUE_W-1){1'b0}}};
    localparam value_t VALUE_MAX = {1'b0, {(lmsl_pkg::VALUE_W-1){1'b1}}};

    // Shapes of the random sequences.
    typedef enum int
    {
        PAT_NOISE,
        PAT_NARROW,
        PAT_RISING,
        PAT_FALLING,
        PAT_EXTREME
    } pattern_t;

    logic clk;
    logic rst_n;

    lmsl_if #(.payload_t(lmsl_pkg::in_item_t))  item_ch ();
    lmsl_if #(.payload_t(lmsl_pkg::out_item_t)) result_ch ();
    lmsl_if #(.payload_t(lmsl_pkg::order_t))    cfg_ch ();

    longest_monotone_subsequence_length_top #(
        .MAX_TAILS  (MAX_TAILS),
        .VALUE_BITS (lmsl_pkg::VALUE_W)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // ------------------------------------------------------------------------
    // Behavioral copy of the tail array. Tails are kept as signed values, so
    // the order test is a plain signed compare at the block's width.
    // ------------------------------------------------------------------------
    value_t               tails [MAX_TAILS];
    int                   tail_total;
    logic                 overflow_held;
    lmsl_pkg::order_t     cur_order;

    // Predicted results, oldest first.
    lmsl_pkg::out_item_t  length_queue [$];

    // Knobs set by the test tasks and read by the sender task and the result side.
    bit        send_gaps_on;
    bit        recv_idle_on;
    bit        hold_start;

    // Run statistics for the closing summary.
    int        error_count;
    int        items_sent;
    int        results_checked;
    int        sequences_closed;
    int        overflow_results;
    int        max_length_seen;
    int        input_stall_cycles;

    // ------------------------------------------------------------------------
    // Clock and watchdog.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A run that outlasts the slowest legal run by a wide margin is declared hung.
    initial
    begin
        #10_000_000;
        $display("ERROR: timeout, %0d results still outstanding", length_queue.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Helpers.
    // ------------------------------------------------------------------------

    // Every failure goes through here: one line is printed and it is counted.
    task automatic report_error(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Gap length used by both sides: mostly short, now and then long.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(20, 60);
    endfunction

    // Runs one element through the tail array and returns the result that the
    // block must produce for it. The scan is a plain first-match search, so
    // it stays well defined even after the order changed mid-sequence and
    // the tails are no longer sorted in the current order.
    function automatic lmsl_pkg::out_item_t place_in_tails(input value_t v,
                                                           input logic last);
        int                  pos;
        lmsl_pkg::out_item_t r;
        pos = tail_total;
        for (int i = 0; i < tail_total; i++)
        begin
            // A tail that is equal to the element is never before it, so an
            // equal value replaces that tail and the subsequence stays strict.
            if (cur_order == lmsl_pkg::ORDER_DECREASING ? (tails[i] <= v)
                                                        : (tails[i] >= v))
            begin
                pos = i;
                break;
            end
        end
        if (pos < tail_total)
        begin
            tails[pos] = v;
        end
        else if (tail_total < MAX_TAILS)
        begin
            tails[tail_total] = v;
            tail_total++;
        end
        else
        begin
            // Store is full: the append is dropped and the flag sticks until
            // the sequence closes.
            overflow_held = 1'b1;
        end
        r.length_so_far = lmsl_pkg::LEN_W'(tail_total);
        r.overflowed    = overflow_held;
        r.sequence_done = last;
        if (last)
        begin
            tail_total    = 0;
            overflow_held = 1'b0;
        end
        return r;
    endfunction

    // Offers one element and returns at the edge where it was accepted.
    // Valid is left high so that the next element can follow back to back;
    // whoever stops sending lowers it through wait_drained.
    task automatic send_item(input value_t v, input logic last);
        lmsl_pkg::in_item_t  beat;
        lmsl_pkg::out_item_t pred;
        int                  gap;
        gap = 0;
        if (send_gaps_on && $urandom_range(0, 99) < 20)
        begin
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.value            = v;
        beat.last_in_sequence = last;
        item_ch.valid <= 1'b1;
        item_ch.data  <= beat;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        pred         = place_in_tails(v, last);
        length_queue = {length_queue, pred};
        items_sent++;
    endtask

    // Stops offering elements and waits until every predicted result has
    // come back. The task always waits for a clock edge, so valid is never lowered
    // and raised again within one time step.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (length_queue.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Writes the order register while the block is idle. Every element gives
    // exactly one result, so an empty prediction queue means an empty chain.
    task automatic write_order(input lmsl_pkg::order_t o);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= o;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        cur_order = o;
    endtask

    // ------------------------------------------------------------------------
    // Result side: drives ready. A hold request from a test task forces a
    // long stall that is counted here; otherwise ready drops at random when
    // idling is enabled.
    // ------------------------------------------------------------------------
    initial
    begin : result_side
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (recv_idle_on && $urandom_range(0, 99) < 25)
            begin
                stall_left = pick_gap() - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker. Values are sampled at the edge, before any update made
    // at that edge, so both sides see the same handshake.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        lmsl_pkg::out_item_t want;
        lmsl_pkg::out_item_t got;
        if (rst_n && item_ch.valid && !item_ch.ready)
        begin
            input_stall_cycles++;
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (length_queue.size() == 0)
            begin
                report_error($sformatf("unexpected result len=%0d ovf=%0b done=%0b",
                    got.length_so_far, got.overflowed, got.sequence_done));
            end
            else
            begin
                want = length_queue.pop_front();
                results_checked++;
                if (got.length_so_far !== want.length_so_far)
                begin
                    report_error($sformatf("result %0d length_so_far got %0d want %0d",
                        results_checked, got.length_so_far, want.length_so_far));
                end
                if (got.overflowed !== want.overflowed)
                begin
                    report_error($sformatf("result %0d overflowed got %b want %b",
                        results_checked, got.overflowed, want.overflowed));
                end
                if (got.sequence_done !== want.sequence_done)
                begin
                    report_error($sformatf("result %0d sequence_done got %b want %b",
                        results_checked, got.sequence_done, want.sequence_done));
                end
                if (want.sequence_done)
                begin
                    sequences_closed++;
                end
                if (want.overflowed)
                begin
                    overflow_results++;
                end
                if (int'(want.length_so_far) > max_length_seen)
                begin
                    max_length_seen = int'(want.length_so_far);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------------

    // Extreme values, an equal value replacing its tail, a run of equal
    // values and a sequence of one element, all in increasing order.
    task automatic test_field_extremes();
        write_order(lmsl_pkg::ORDER_INCREASING);
        send_item(VALUE_MIN, 1'b0);
        send_item(VALUE_MAX, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(VALUE_MAX, 1'b0);
        send_item(32'sd1, 1'b1);
        send_item(32'sd7, 1'b0);
        send_item(32'sd7, 1'b0);
        send_item(32'sd7, 1'b1);
        send_item(VALUE_MIN, 1'b1);
    endtask

    // Same corners in decreasing order, including an equal minimum.
    task automatic test_descending();
        write_order(lmsl_pkg::ORDER_DECREASING);
        send_item(VALUE_MAX, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(VALUE_MIN, 1'b0);
        send_item(VALUE_MIN, 1'b0);
        send_item(32'sd5, 1'b1);
    endtask

    // The order flips while a sequence is open. The tails built in one
    // order are then searched in the other one.
    task automatic test_order_switch();
        write_order(lmsl_pkg::ORDER_INCREASING);
        send_item(32'sd1, 1'b0);
        send_item(32'sd2, 1'b0);
        send_item(32'sd3, 1'b0);
        write_order(lmsl_pkg::ORDER_DECREASING);
        send_item(32'sd2, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(-32'sd5, 1'b0);
        write_order(lmsl_pkg::ORDER_INCREASING);
        send_item(32'sd4, 1'b1);
    endtask

    // A long monotone run fills the whole store; further appends are dropped
    // and the overflow flag must stay up until the sequence closes. A few
    // elements that only replace tails are mixed in along the way.
    task automatic test_store_full(input lmsl_pkg::order_t o);
        value_t run_val;
        value_t v;
        int     appended;
        write_order(o);
        appended = 0;
        if (o == lmsl_pkg::ORDER_INCREASING)
        begin
            run_val = VALUE_MIN + value_t'($urandom_range(0, 1000));
        end
        else
        begin
            run_val = VALUE_MAX - value_t'($urandom_range(0, 1000));
        end
        while (appended < MAX_TAILS + 8)
        begin
            if (appended > 0 && $urandom_range(0, 99) < 8)
            begin
                // Stays on the near side of the run, so it never blocks the
                // next append.
                if (o == lmsl_pkg::ORDER_INCREASING)
                begin
                    v = VALUE_MIN + value_t'($urandom_range(0, run_val ^ VALUE_MIN));
                end
                else
                begin
                    v = run_val + value_t'($urandom_range(0, VALUE_MAX - run_val));
                end
                send_item(v, 1'b0);
            end
            else
            begin
                if (o == lmsl_pkg::ORDER_INCREASING)
                begin
                    run_val = run_val + value_t'($urandom_range(1, 1 << 20));
                end
                else
                begin
                    run_val = run_val - value_t'($urandom_range(1, 1 << 20));
                end
                appended++;
                send_item(run_val, appended == MAX_TAILS + 8);
            end
        end
    endtask

    // The result port is held off for a long stretch while the sender keeps
    // offering elements with no gaps, so the chain fills and the input side
    // must stall without losing or duplicating anything.
    task automatic test_output_backpressure();
        value_t v;
        send_gaps_on = 1'b0;
        recv_idle_on = 1'b0;
        hold_start   = 1'b1;
        for (int n = 0; n < 350; n++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                v = $signed($urandom);
            end
            else
            begin
                v = value_t'($urandom_range(0, 16)) - 32'sd8;
            end
            send_item(v, $urandom_range(0, 99) < 5);
        end
        wait_drained();
    endtask

    // Random sequences of several shapes, in phases with different orders and
    // idling. Most sequences close with a last marker; some are left open
    // across a phase boundary, so the order also changes inside a sequence.
    task automatic test_random_sequences(input int item_budget);
        pattern_t shape;
        value_t   base;
        value_t   v;
        int       step;
        int       len;
        int       phase_end;
        int       r;
        bit       close_it;
        bit       pause_mid;
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase == 0)
            begin
                write_order(lmsl_pkg::ORDER_INCREASING);
                send_gaps_on = 1'b0;
                recv_idle_on = 1'b0;
            end
            else
            begin
                write_order(phase == 1 ? lmsl_pkg::ORDER_DECREASING
                                       : lmsl_pkg::order_t'($urandom_range(0, 1)));
                send_gaps_on = $urandom_range(0, 3) != 0;
                recv_idle_on = $urandom_range(0, 3) != 0;
            end
            phase_end = items_sent + item_budget / 5;
            while (items_sent < phase_end)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    len = 1;
                end
                else if (r < 75)
                begin
                    len = $urandom_range(2, 24);
                end
                else
                begin
                    len = $urandom_range(25, 80);
                end
                shape     = pattern_t'($urandom_range(0, 4));
                close_it  = $urandom_range(0, 99) < 90;
                pause_mid = $urandom_range(0, 99) < 5;
                base      = $signed($urandom);
                step      = $urandom_range(1, 1000);
                for (int k = 0; k < len; k++)
                begin
                    case (shape)
                        PAT_NOISE:
                        begin
                            v = $signed($urandom);
                        end
                        PAT_NARROW:
                        begin
                            v = value_t'($urandom_range(0, 8)) - 32'sd4;
                        end
                        PAT_RISING:
                        begin
                            v = ($urandom_range(0, 99) < 15) ? $signed($urandom)
                                                             : base + value_t'(k * step);
                        end
                        PAT_FALLING:
                        begin
                            v = ($urandom_range(0, 99) < 15) ? $signed($urandom)
                                                             : base - value_t'(k * step);
                        end
                        default:
                        begin
                            case ($urandom_range(0, 5))
                                0:       v = VALUE_MIN;
                                1:       v = VALUE_MAX;
                                2:       v = 32'sd0;
                                3:       v = -32'sd1;
                                4:       v = VALUE_MIN + 32'sd1;
                                default: v = VALUE_MAX - 32'sd1;
                            endcase
                        end
                    endcase
                    // Now and then the sender stops in the middle of a
                    // sequence until every result is back.
                    if (pause_mid && k == len / 2)
                    begin
                        wait_drained();
                    end
                    send_item(v, close_it && k == len - 1);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = lmsl_pkg::ORDER_INCREASING;
        result_ch.ready = 1'b0;

        tail_total    = 0;
        overflow_held = 1'b0;
        cur_order     = lmsl_pkg::ORDER_INCREASING;
        send_gaps_on  = 1'b1;
        recv_idle_on  = 1'b1;
        hold_start    = 1'b0;

        error_count        = 0;
        items_sent         = 0;
        results_checked    = 0;
        sequences_closed   = 0;
        overflow_results   = 0;
        max_length_seen    = 0;
        input_stall_cycles = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_descending();
        test_order_switch();
        test_store_full(lmsl_pkg::ORDER_INCREASING);
        test_store_full(lmsl_pkg::ORDER_DECREASING);
        test_output_backpressure();
        test_random_sequences(500);

        // Let the chain run empty, then allow a full pass through it so that
        // any stray result still shows up as unexpected.
        wait_drained();
        repeat (MAX_TAILS + 20) @(posedge clk);

        $display("Summary: %0d elements, %0d results checked, %0d sequences closed.",
            items_sent, results_checked, sequences_closed);
        $display("Summary: longest length %0d, %0d saturated results, %0d input stall cycles.",
            max_length_seen, overflow_results, input_stall_cycles);
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches found", error_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
